// ===== rtl/rounded_rect_vertex_gen_unit_defines.svh =====
// assertion macros shared by the rtl
`ifndef ROUNDED_RECT_VERTEX_GEN_UNIT_DEFINES_SVH
`define ROUNDED_RECT_VERTEX_GEN_UNIT_DEFINES_SVH

// same-cycle implication
`define RRVG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrvg check failed");

// next-cycle implication
`define RRVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrvg check failed");

`endif

// ===== rtl/rrvg_pkg.sv =====
package rrvg_pkg;

   localparam int MAX_CORNER_POINTS = 256;
   localparam int CORDIC_STEPS = 16;
   localparam int QUO_BITS = 17;
   localparam int DVD_BITS = 24;
   localparam int DIV_BITS = 8;
   localparam int XY_BITS = 18;
   localparam int Z_BITS = 20;

   localparam logic [1:0] CSR_RECT_WIDTH = 2'd0;
   localparam logic [1:0] CSR_RECT_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CORNER_RADIUS = 2'd2;
   localparam logic [1:0] CSR_POINTS = 2'd3;

   localparam logic signed [XY_BITS-1:0] CORDIC_X0 = 18'sd19898;
   localparam logic [15:0] ONE_Q15 = 16'd32768;

   localparam logic [15:0] ATAN_TAB [CORDIC_STEPS] = '{
      16'd32768, 16'd19343, 16'd10221, 16'd5188, 16'd2604, 16'd1303, 16'd652, 16'd326,
      16'd163, 16'd81, 16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1
   };

   // sideband that travels with each beat
   typedef struct packed {
      logic       valid;
      logic       idx_ok;
      logic       no_step;
      logic [1:0] quad;
      logic [9:0] idx;
   } side_type;

endpackage

// ===== rtl/rounded_rect_vertex_gen_unit.sv =====
// throughput: one vertex per cycle; the whole pipeline moves as one and
// holds while a response beat waits under rsp_stall
// stages: 1 index split, 17 phase divide, 17 cordic, 1 multiply, 1 result
// reset: synchronous, clears valid bits and config (points per corner to 8)
module rounded_rect_vertex_gen_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_vertex_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_point_x,
   output logic [15:0] rsp_point_y,
   output logic        rsp_index_valid,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import rrvg_pkg::*;
`include "rounded_rect_vertex_gen_unit_defines.svh"

   logic [15:0] rect_width_ff;
   logic [15:0] rect_height_ff;
   logic [15:0] corner_radius_ff;
   logic [8:0]  points_ff;
   logic [15:0] r_eff_ff;
   logic [15:0] r_eff_in;
   logic        advance;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rect_width_ff    <= '0;
         rect_height_ff   <= '0;
         corner_radius_ff <= '0;
         points_ff        <= 9'd8;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RECT_WIDTH:    rect_width_ff    <= csr_wdata;
            CSR_RECT_HEIGHT:   rect_height_ff   <= csr_wdata;
            CSR_CORNER_RADIUS: corner_radius_ff <= csr_wdata;
            CSR_POINTS:        points_ff        <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // clamped radius
   always_comb begin
      logic [15:0] half;
      half = ((rect_width_ff < rect_height_ff) ? rect_width_ff : rect_height_ff) >> 1;
      r_eff_in = (corner_radius_ff > half) ? half : corner_radius_ff;
   end

   always_ff @(posedge clock) begin
      r_eff_ff <= r_eff_in;
   end

   // whole pipeline holds while a response beat waits
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // index split into quadrant and arc position
   logic [8:0]          n_eff;
   logic [10:0]         n1;
   logic [10:0]         n2;
   logic [10:0]         n3;
   logic [10:0]         n4;
   logic [10:0]         idx_w;
   logic [1:0]          quad;
   logic [10:0]         base;
   logic [7:0]          k;
   logic [DIV_BITS-1:0] divisor;
   side_type            side_in;
   side_type            s0_side_ff;
   logic [DVD_BITS-1:0] s0_dvd_ff;

   assign n_eff   = (points_ff > 9'(MAX_CORNER_POINTS)) ? 9'(MAX_CORNER_POINTS) : points_ff;
   assign n1      = {2'b00, n_eff};
   assign n2      = {1'b0, n_eff, 1'b0};
   assign n3      = n1 + n2;
   assign n4      = {n_eff, 2'b00};
   assign idx_w   = {1'b0, req_vertex_index};
   assign divisor = DIV_BITS'(n_eff - 9'd1);

   always_comb begin
      if (idx_w >= n3) begin
         quad = 2'd3;
         base = n3;
      end else if (idx_w >= n2) begin
         quad = 2'd2;
         base = n2;
      end else if (idx_w >= n1) begin
         quad = 2'd1;
         base = n1;
      end else begin
         quad = 2'd0;
         base = '0;
      end
      k = 8'(idx_w - base);
      side_in.valid   = req_valid;
      side_in.idx_ok  = idx_w < n4;
      side_in.no_step = n_eff <= 9'd1;
      side_in.quad    = quad;
      side_in.idx     = req_vertex_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_side_ff.valid <= 1'b0;
      end else if (advance) begin
         s0_side_ff.valid <= side_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_side_ff.idx_ok  <= side_in.idx_ok;
         s0_side_ff.no_step <= side_in.no_step;
         s0_side_ff.quad    <= side_in.quad;
         s0_side_ff.idx     <= side_in.idx;
         s0_dvd_ff <= {k, 16'd0} + DVD_BITS'(divisor >> 1);
      end
   end

   // phase divide and sine/cosine
   side_type            div_side;
   logic [QUO_BITS-1:0] phase;
   side_type            cs_side;
   logic [15:0]         cos_q15;
   logic [15:0]         sin_q15;

   rrvg_phase_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .side_in  (s0_side_ff),
      .dividend (s0_dvd_ff),
      .divisor  (divisor),
      .side_out (div_side),
      .phase    (phase)
   );

   rrvg_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .side_in  (div_side),
      .phase    (phase),
      .side_out (cs_side),
      .cos_q15  (cos_q15),
      .sin_q15  (sin_q15)
   );

   // radius scaling
   side_type    mul_side_ff;
   logic [31:0] rc_prod_ff;
   logic [31:0] rs_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_side_ff.valid <= 1'b0;
      end else if (advance) begin
         mul_side_ff.valid <= cs_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_side_ff.idx_ok  <= cs_side.idx_ok;
         mul_side_ff.no_step <= cs_side.no_step;
         mul_side_ff.quad    <= cs_side.quad;
         mul_side_ff.idx     <= cs_side.idx;
         rc_prod_ff <= r_eff_ff * cos_q15;
         rs_prod_ff <= r_eff_ff * sin_q15;
      end
   end

   // final corner placement
   logic [31:0] rc_sum;
   logic [31:0] rs_sum;
   logic [15:0] rc;
   logic [15:0] rs;
   logic [15:0] px_in;
   logic [15:0] py_in;
   logic        rsp_valid_ff;
   logic [15:0] rsp_x_ff;
   logic [15:0] rsp_y_ff;
   logic        rsp_ok_ff;

   assign rc_sum = rc_prod_ff + 32'd16384;
   assign rs_sum = rs_prod_ff + 32'd16384;
   assign rc     = rc_sum[30:15];
   assign rs     = rs_sum[30:15];

   always_comb begin
      px_in = '0;
      py_in = '0;
      if (!mul_side_ff.idx_ok) begin
         px_in = '0;
         py_in = '0;
      end else if (r_eff_ff == '0) begin
         case (mul_side_ff.idx)
            10'd0: begin
               px_in = '0;
               py_in = '0;
            end
            10'd1: begin
               px_in = rect_width_ff;
               py_in = '0;
            end
            10'd2: begin
               px_in = rect_width_ff;
               py_in = rect_height_ff;
            end
            default: begin
               px_in = '0;
               py_in = rect_height_ff;
            end
         endcase
      end else begin
         case (mul_side_ff.quad)
            2'd0: begin
               px_in = rect_width_ff - r_eff_ff + rs;
               py_in = r_eff_ff - rc;
            end
            2'd1: begin
               px_in = rect_width_ff - r_eff_ff + rc;
               py_in = rect_height_ff - r_eff_ff + rs;
            end
            2'd2: begin
               px_in = r_eff_ff - rs;
               py_in = rect_height_ff - r_eff_ff + rc;
            end
            default: begin
               px_in = r_eff_ff - rc;
               py_in = r_eff_ff - rs;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mul_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_x_ff  <= px_in;
         rsp_y_ff  <= py_in;
         rsp_ok_ff <= mul_side_ff.idx_ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_index_valid = rsp_ok_ff;

   // checks
   `RRVG_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_valid && !rsp_index_valid, rsp_point_x == 16'd0 && rsp_point_y == 16'd0)
   `RRVG_ASSERT_NEXT(a_radius_bound, clock, reset, !csr_write, r_eff_ff <= corner_radius_ff && (r_eff_ff <= (rect_width_ff >> 1) || r_eff_ff <= (rect_height_ff >> 1)))

endmodule

// ===== rtl/rrvg_phase_div.sv =====
module rrvg_phase_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  rrvg_pkg::side_type                  side_in,
   input  logic [rrvg_pkg::DVD_BITS-1:0]       dividend,
   input  logic [rrvg_pkg::DIV_BITS-1:0]       divisor,
   output rrvg_pkg::side_type                  side_out,
   output logic [rrvg_pkg::QUO_BITS-1:0]       phase
);
   import rrvg_pkg::*;

   side_type                side_ff [QUO_BITS];
   logic [DIV_BITS-1:0]     rem_ff  [QUO_BITS];
   logic [QUO_BITS-1:0]     low_ff  [QUO_BITS];
   logic [QUO_BITS-1:0]     quo_ff  [QUO_BITS];

   // one quotient bit per stage, restoring division
   for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
      side_type                side_src;
      logic [DIV_BITS-1:0]     rem_src;
      logic [QUO_BITS-1:0]     low_src;
      logic [QUO_BITS-1:0]     quo_src;
      logic [DIV_BITS:0]       trial;
      logic                    ge;

      if (j == 0) begin : g_first
         assign side_src = side_in;
         assign rem_src  = {1'b0, dividend[DVD_BITS-1:QUO_BITS]};
         assign low_src  = dividend[QUO_BITS-1:0];
         assign quo_src  = '0;
      end else begin : g_next
         assign side_src = side_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign low_src  = low_ff[j-1];
         assign quo_src  = quo_ff[j-1];
      end

      assign trial = {rem_src, low_src[QUO_BITS-1]};
      assign ge    = trial >= {1'b0, divisor};

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j].valid <= 1'b0;
         end else if (advance) begin
            side_ff[j].valid <= side_src.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            side_ff[j].idx_ok  <= side_src.idx_ok;
            side_ff[j].no_step <= side_src.no_step;
            side_ff[j].quad    <= side_src.quad;
            side_ff[j].idx     <= side_src.idx;
            rem_ff[j] <= ge ? DIV_BITS'(trial - {1'b0, divisor}) : trial[DIV_BITS-1:0];
            low_ff[j] <= {low_src[QUO_BITS-2:0], 1'b0};
            quo_ff[j] <= {quo_src[QUO_BITS-2:0], ge};
         end
      end
   end

   // single point per arc has no angular step
   assign side_out = side_ff[QUO_BITS-1];
   assign phase    = side_ff[QUO_BITS-1].no_step ? '0 : quo_ff[QUO_BITS-1];

endmodule

// ===== rtl/rrvg_cordic.sv =====
module rrvg_cordic (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  rrvg_pkg::side_type              side_in,
   input  logic [rrvg_pkg::QUO_BITS-1:0]   phase,
   output rrvg_pkg::side_type              side_out,
   output logic [15:0]                     cos_q15,
   output logic [15:0]                     sin_q15
);
   import rrvg_pkg::*;

   side_type                   side_ff [CORDIC_STEPS];
   logic signed [XY_BITS-1:0]  x_ff    [CORDIC_STEPS];
   logic signed [XY_BITS-1:0]  y_ff    [CORDIC_STEPS];
   logic signed [Z_BITS-1:0]   z_ff    [CORDIC_STEPS];
   side_type                   side_out_ff;
   logic [15:0]                cos_ff;
   logic [15:0]                sin_ff;

   // one rotation per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      side_type                   side_src;
      logic signed [XY_BITS-1:0]  x_src;
      logic signed [XY_BITS-1:0]  y_src;
      logic signed [Z_BITS-1:0]   z_src;
      logic signed [XY_BITS-1:0]  dx;
      logic signed [XY_BITS-1:0]  dy;
      logic signed [Z_BITS-1:0]   da;

      if (i == 0) begin : g_first
         assign side_src = side_in;
         assign x_src    = CORDIC_X0;
         assign y_src    = '0;
         assign z_src    = signed'({{(Z_BITS-QUO_BITS){1'b0}}, phase});
      end else begin : g_next
         assign side_src = side_ff[i-1];
         assign x_src    = x_ff[i-1];
         assign y_src    = y_ff[i-1];
         assign z_src    = z_ff[i-1];
      end

      assign dx = y_src >>> i;
      assign dy = x_src >>> i;
      assign da = signed'({{(Z_BITS-16){1'b0}}, ATAN_TAB[i]});

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i].valid <= 1'b0;
         end else if (advance) begin
            side_ff[i].valid <= side_src.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            side_ff[i].idx_ok  <= side_src.idx_ok;
            side_ff[i].no_step <= side_src.no_step;
            side_ff[i].quad    <= side_src.quad;
            side_ff[i].idx     <= side_src.idx;
            if (!z_src[Z_BITS-1]) begin
               x_ff[i] <= x_src - dx;
               y_ff[i] <= y_src + dy;
               z_ff[i] <= z_src - da;
            end else begin
               x_ff[i] <= x_src + dx;
               y_ff[i] <= y_src - dy;
               z_ff[i] <= z_src + da;
            end
         end
      end
   end

   // clamp to [0, 1.0] in q1.15
   function automatic logic [15:0] clamp_q15(input logic signed [XY_BITS-1:0] v);
      logic [15:0] res;
      if (v[XY_BITS-1]) begin
         res = '0;
      end else if (v > signed'({2'b00, ONE_Q15})) begin
         res = ONE_Q15;
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         side_out_ff.valid <= 1'b0;
      end else if (advance) begin
         side_out_ff.valid <= side_ff[CORDIC_STEPS-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_out_ff.idx_ok  <= side_ff[CORDIC_STEPS-1].idx_ok;
         side_out_ff.no_step <= side_ff[CORDIC_STEPS-1].no_step;
         side_out_ff.quad    <= side_ff[CORDIC_STEPS-1].quad;
         side_out_ff.idx     <= side_ff[CORDIC_STEPS-1].idx;
         cos_ff <= clamp_q15(x_ff[CORDIC_STEPS-1]);
         sin_ff <= clamp_q15(y_ff[CORDIC_STEPS-1]);
      end
   end

   assign side_out = side_out_ff;
   assign cos_q15  = cos_ff;
   assign sin_q15  = sin_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import rrvg_pkg::*;

   localparam int MAX_POINTS = 256;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        ok;
   } vertex_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [9:0]  req_vertex_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_point_x;
   logic [15:0] rsp_point_y;
   logic        rsp_index_valid;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_RECT_WIDTH;
   logic [15:0] csr_wdata = '0;

   // shadow of the block's registers
   logic [15:0] shadow_width = '0;
   logic [15:0] shadow_height = '0;
   logic [15:0] shadow_radius = '0;
   logic [8:0]  shadow_points = 9'd8;

   vertex_type expected_vertices[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  idling_on = 1'b1;
   bit  hold_request = 1'b0;

   rounded_rect_vertex_gen_unit dut (.*);

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL rounded_rect_vertex_gen_unit");
         $finish;
      end
   end

   // cordic sine and cosine of a quarter-turn phase, q1.15
   function automatic void cordic_sin_cos(input int phase, output int c, output int s);
      int x, y, z, dx, dy;
      x = int'(CORDIC_X0);
      y = 0;
      z = phase;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - int'(ATAN_TAB[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + int'(ATAN_TAB[i]);
         end
      end
      c = (x < 0) ? 0 : (x > 32768) ? 32768 : x;
      s = (y < 0) ? 0 : (y > 32768) ? 32768 : y;
   endfunction

   // outline vertex for an index under the current registers
   function automatic vertex_type outline_vertex(input logic [9:0] vidx);
      vertex_type v;
      longint n, w, h, r, maxr, q, k, phase, rc, rs, px, py;
      int c, s;
      n = (shadow_points > MAX_POINTS) ? MAX_POINTS : shadow_points;
      w = shadow_width;
      h = shadow_height;
      r = shadow_radius;
      maxr = ((w < h) ? w : h) >> 1;
      if (r > maxr) r = maxr;
      v = '0;
      px = 0;
      py = 0;
      if (vidx >= 4 * n) return v;
      if (r == 0) begin
         // plain corners
         case (vidx)
            10'd0: begin px = 0; py = 0; end
            10'd1: begin px = w; py = 0; end
            10'd2: begin px = w; py = h; end
            default: begin px = 0; py = h; end
         endcase
      end else begin
         q = vidx / n;
         k = vidx % n;
         phase = (n > 1) ? (k * 65536 + (n - 1) / 2) / (n - 1) : 0;
         cordic_sin_cos(int'(phase), c, s);
         rc = (r * c + 16384) >> 15;
         rs = (r * s + 16384) >> 15;
         case (q)
            0: begin px = w - r + rs; py = r - rc; end
            1: begin px = w - r + rc; py = h - r + rs; end
            2: begin px = r - rs; py = h - r + rc; end
            default: begin px = r - rc; py = r - rs; end
         endcase
      end
      v.x = px[15:0];
      v.y = py[15:0];
      v.ok = 1'b1;
      return v;
   endfunction

   // register write, only while idle
   task automatic write_reg(input logic [1:0] ridx, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= ridx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (ridx)
         CSR_RECT_WIDTH:    shadow_width = value;
         CSR_RECT_HEIGHT:   shadow_height = value;
         CSR_CORNER_RADIUS: shadow_radius = value;
         default:           shadow_points = value[8:0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_shape(input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] r, input logic [15:0] n);
      write_reg(CSR_RECT_WIDTH, w);
      write_reg(CSR_RECT_HEIGHT, h);
      write_reg(CSR_CORNER_RADIUS, r);
      write_reg(CSR_POINTS, n);
   endtask

   // one request beat
   task automatic send_vertex(input logic [9:0] vidx);
      int gap;
      gap = idling_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_index <= vidx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_vertices.push_back(outline_vertex(vidx));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver stalls
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            gap = idling_on ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin
      vertex_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_vertices.size() == 0) begin
            $display("%0t: unexpected beat x=%0d y=%0d ok=%0d", $time,
                     rsp_point_x, rsp_point_y, rsp_index_valid);
            error_count++;
         end else begin
            want = expected_vertices.pop_front();
            if (rsp_point_x !== want.x) begin
               $display("%0t: point_x expected %0d actual %0d", $time, want.x, rsp_point_x);
               error_count++;
            end
            if (rsp_point_y !== want.y) begin
               $display("%0t: point_y expected %0d actual %0d", $time, want.y, rsp_point_y);
               error_count++;
            end
            if (rsp_index_valid !== want.ok) begin
               $display("%0t: index_valid expected %0d actual %0d", $time, want.ok,
                        rsp_index_valid);
               error_count++;
            end
         end
      end
   end

   // reset values: zero size, zero radius, eight points
   task automatic test_reset_values();
      logic [9:0] list [6] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd31, 10'd32};
      foreach (list[i]) send_vertex(list[i]);
      wait_idle();
   endtask

   // arc ends, clamping, corner cases of the point count
   task automatic test_directed();
      set_shape(16'd1600, 16'd800, 16'd160, 16'd8);
      send_vertex(10'd0); send_vertex(10'd7); send_vertex(10'd8);
      send_vertex(10'd16); send_vertex(10'd31); send_vertex(10'd32);
      wait_idle();
      // radius clamped to half the smaller side, largest sizes
      set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2);
      send_vertex(10'd0); send_vertex(10'd3); send_vertex(10'd5); send_vertex(10'd7);
      wait_idle();
      // single point per arc
      write_reg(CSR_POINTS, 16'd1);
      send_vertex(10'd0); send_vertex(10'd2); send_vertex(10'd3); send_vertex(10'd4);
      wait_idle();
      // no points: all indices invalid
      write_reg(CSR_POINTS, 16'd0);
      send_vertex(10'd0); send_vertex(10'd1023);
      wait_idle();
      // count above the maximum saturates
      write_reg(CSR_POINTS, 16'h01FF);
      send_vertex(10'd1023); send_vertex(10'd255); send_vertex(10'd256);
      wait_idle();
   endtask

   // random shapes with mostly in-range indices
   task automatic test_random_shapes();
      logic [15:0] w, h, r, n;
      int lim;
      for (int phase = 0; phase < 12; phase++) begin
         idling_on = (phase % 4) != 3;
         w = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
         h = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
         case ($urandom_range(0, 3))
            0: r = 16'd0;
            1: r = 16'($urandom);
            default: r = 16'($urandom_range(1, 1200));
         endcase
         case ($urandom_range(0, 5))
            0: n = 16'd2;
            1: n = 16'd256;
            2: n = 16'($urandom_range(0, 511)) | 16'($urandom & 16'hFE00);
            default: n = 16'($urandom_range(2, 40));
         endcase
         set_shape(w, h, r, n);
         lim = (shadow_points == 0) ? 1023 :
               (shadow_points > 255) ? 1023 : 4 * shadow_points - 1;
         repeat (55) begin
            if ($urandom_range(0, 7) == 0) send_vertex(10'($urandom));
            else send_vertex(10'($urandom_range(0, lim)));
         end
         wait_idle();
      end
      idling_on = 1'b1;
   endtask

   // long receiver hold while requests keep coming
   task automatic test_backpressure();
      set_shape(16'd3000, 16'd2000, 16'd500, 16'd16);
      idling_on = 1'b0;
      hold_request = 1'b1;
      repeat (80) send_vertex(10'($urandom_range(0, 63)));
      idling_on = 1'b1;
      wait_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed();
      test_random_shapes();
      test_backpressure();
      if (error_count == 0) begin
         $display("PASS rounded_rect_vertex_gen_unit");
      end else begin
         $display("FAIL rounded_rect_vertex_gen_unit");
      end
      $finish;
   end

endmodule
